// ----- hdl/mkrs_pkg.sv -----
// Shared constants and controller/datapath signal groups for the record sorter.
`timescale 1ns / 1ps

package mkrs_pkg;

    // Batch capacity and key geometry.
    localparam int MAX_ENTRIES = 64;
    localparam int KEY_BITS    = 40;
    localparam int REC_W       = 64;

    // Index into one bank, and a count that can hold the capacity itself.
    localparam int IDX_W     = $clog2(MAX_ENTRIES);
    localparam int CNT_W     = $clog2(MAX_ENTRIES + 1);
    localparam int MEM_DEPTH = 2 << IDX_W;

    typedef logic [REC_W-1:0] t_rec;
    typedef logic [CNT_W-1:0] t_cnt;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // store an accepted record
        logic start;       // begin sorting the stored batch
        logic pair_init;   // set up the merge of two runs
        logic merge_rd;    // read the heads of both runs
        logic merge_step;  // write the smaller head to the other bank
        logic pair_next;   // move to the next pair of runs
        logic pass_next;   // double the run width and swap banks
        logic drain_init;  // rewind the output index
        logic drain_rd;    // read the next sorted record
        logic drain_out;   // hand the record to the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sort_done;   // run width already covers the batch
        logic pair_last;   // the current merge writes its final record
        logic last_pair;   // no further pair in this pass
        logic last_pass;   // the next width covers the batch
        logic drain_last;  // the record being handed out ends the batch
        logic out_free;    // the output register can take a record
    } t_sts;

endpackage

// ----- hdl/mkrs_if.sv -----
// Handshake channels for input records and sorted results.
`timescale 1ns / 1ps

interface mkrs_rec_if;
    logic              valid;
    logic              ready;
    mkrs_pkg::t_rec    record;
    logic              batch_end;

    modport source (output valid, output record, output batch_end, input ready);
    modport sink   (input valid, input record, input batch_end, output ready);
endinterface

interface mkrs_res_if;
    logic              valid;
    logic              ready;
    mkrs_pkg::t_rec    sorted_record;
    logic              final_flag;
    logic              overflow;

    modport source (output valid, output sorted_record, output final_flag,
                    output overflow, input ready);
    modport sink   (input valid, input sorted_record, input final_flag,
                    input overflow, output ready);
endinterface

// ----- hdl/mkrs_dp.sv -----
// Datapath: record memory in two banks, merge counters and output register.
`timescale 1ns / 1ps

module mkrs_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mkrs_pkg::t_cmd  i_cmd,
    output mkrs_pkg::t_sts  o_sts,
    input  mkrs_pkg::t_rec  i_record,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output mkrs_pkg::t_rec  o_sorted_record,
    output logic            o_final_flag,
    output logic            o_overflow
);

    localparam int CW = mkrs_pkg::CNT_W;
    localparam int IW = mkrs_pkg::IDX_W;

    // Two banks of records; the bank bit is the top address bit.
    mkrs_pkg::t_rec r_mem [mkrs_pkg::MEM_DEPTH];
    mkrs_pkg::t_rec r_rd_a;
    mkrs_pkg::t_rec r_rd_b;

    logic [CW-1:0] r_count;
    logic          r_ovf;
    logic [CW:0]   r_w;
    logic          r_bank;
    logic [CW-1:0] r_lo;
    logic [CW-1:0] r_i;
    logic [CW-1:0] r_mid;
    logic [CW-1:0] r_j;
    logic [CW-1:0] r_end;
    logic [CW-1:0] r_k;
    logic [CW-1:0] r_d;

    logic          r_out_valid;
    mkrs_pkg::t_rec r_out_rec;
    logic          r_out_final;
    logic          r_out_ovf;

    logic [CW+1:0] w_n_ext;
    logic [CW+1:0] w_sum_mid;
    logic [CW+1:0] w_sum_end;
    logic [CW+1:0] w_w2;
    logic          w_i_ok;
    logic          w_j_ok;
    logic          w_take_a;
    logic [CW-1:0] w_rd_idx;
    logic          w_full;

    // Run bounds for the pair that starts at r_lo.
    assign w_n_ext   = {2'b00, r_count};
    assign w_sum_mid = {2'b00, r_lo} + {1'b0, r_w};
    assign w_w2      = {r_w, 1'b0};
    assign w_sum_end = {2'b00, r_lo} + w_w2;
    assign w_full    = (r_count == CW'(mkrs_pkg::MAX_ENTRIES));

    // Stable merge choice: the left run wins on equal keys.
    assign w_i_ok   = (r_i < r_mid);
    assign w_j_ok   = (r_j < r_end);
    assign w_take_a = w_i_ok && (!w_j_ok ||
                      (r_rd_a[mkrs_pkg::KEY_BITS-1:0] <= r_rd_b[mkrs_pkg::KEY_BITS-1:0]));

    assign w_rd_idx = i_cmd.drain_rd ? r_d : r_i;

    // Status toward the controller.
    assign o_sts.sort_done  = ({1'b0, r_w} >= w_n_ext);
    assign o_sts.pair_last  = ((r_k + CW'(1)) == r_end);
    assign o_sts.last_pair  = (w_sum_end >= w_n_ext);
    assign o_sts.last_pass  = (w_w2 >= w_n_ext);
    assign o_sts.drain_last = ((r_d + CW'(1)) == r_count);
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    // Memory write and read ports.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && !w_full) begin
            r_mem[{1'b0, r_count[IW-1:0]}] <= i_record;
        end else if (i_cmd.merge_step) begin
            r_mem[{~r_bank, r_k[IW-1:0]}] <= w_take_a ? r_rd_a : r_rd_b;
        end
        if (i_cmd.merge_rd || i_cmd.drain_rd) begin
            r_rd_a <= r_mem[{r_bank, w_rd_idx[IW-1:0]}];
        end
        if (i_cmd.merge_rd) begin
            r_rd_b <= r_mem[{r_bank, r_j[IW-1:0]}];
        end
    end

    // Batch count, overflow and merge bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_w     <= '0;
            r_bank  <= 1'b0;
            r_lo    <= '0;
            r_i     <= '0;
            r_mid   <= '0;
            r_j     <= '0;
            r_end   <= '0;
            r_k     <= '0;
            r_d     <= '0;
        end else begin
            if (i_cmd.load) begin
                if (w_full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_count <= r_count + CW'(1);
                end
            end
            if (i_cmd.start) begin
                r_w    <= (CW + 1)'(1);
                r_bank <= 1'b0;
                r_lo   <= '0;
            end
            if (i_cmd.pair_init) begin
                r_i   <= r_lo;
                r_k   <= r_lo;
                r_mid <= (w_sum_mid < w_n_ext) ? w_sum_mid[CW-1:0] : r_count;
                r_j   <= (w_sum_mid < w_n_ext) ? w_sum_mid[CW-1:0] : r_count;
                r_end <= (w_sum_end < w_n_ext) ? w_sum_end[CW-1:0] : r_count;
            end
            if (i_cmd.merge_step) begin
                if (w_take_a) begin
                    r_i <= r_i + CW'(1);
                end else begin
                    r_j <= r_j + CW'(1);
                end
                r_k <= r_k + CW'(1);
            end
            if (i_cmd.pair_next) begin
                r_lo <= w_sum_end[CW-1:0];
            end
            if (i_cmd.pass_next) begin
                r_w    <= w_w2[CW:0];
                r_bank <= ~r_bank;
                r_lo   <= '0;
            end
            if (i_cmd.drain_init) begin
                r_d <= '0;
            end
            if (i_cmd.drain_out) begin
                r_d <= r_d + CW'(1);
                if (o_sts.drain_last) begin
                    r_count <= '0;
                    r_ovf   <= 1'b0;
                end
            end
        end
    end

    // Output register decouples the drain from the result channel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.drain_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.drain_out) begin
            r_out_rec   <= r_rd_a;
            r_out_final <= o_sts.drain_last;
            r_out_ovf   <= r_ovf;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_sorted_record = r_out_rec;
    assign o_final_flag    = r_out_final;
    assign o_overflow      = r_out_ovf;

endmodule

// ----- hdl/mkrs_ctrl.sv -----
// Controller: sequences loading, bottom-up merge passes and draining.
`timescale 1ns / 1ps

module mkrs_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_batch_end,
    input  mkrs_pkg::t_sts  i_sts,
    output logic            o_in_ready,
    output mkrs_pkg::t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_LOAD,
        S_START,
        S_PASS,
        S_MRD,
        S_MCMP,
        S_NEXT,
        S_DRN_RD,
        S_DRN_OUT
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_LOAD);

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_LOAD: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_in_batch_end) begin
                        o_cmd.start = 1'b1;
                        n_state     = S_START;
                    end
                end
            end
            S_START: begin
                if (i_sts.sort_done) begin
                    o_cmd.drain_init = 1'b1;
                    n_state          = S_DRN_RD;
                end else begin
                    n_state = S_PASS;
                end
            end
            S_PASS: begin
                o_cmd.pair_init = 1'b1;
                n_state         = S_MRD;
            end
            S_MRD: begin
                o_cmd.merge_rd = 1'b1;
                n_state        = S_MCMP;
            end
            S_MCMP: begin
                o_cmd.merge_step = 1'b1;
                n_state          = i_sts.pair_last ? S_NEXT : S_MRD;
            end
            S_NEXT: begin
                if (!i_sts.last_pair) begin
                    o_cmd.pair_next = 1'b1;
                    n_state         = S_PASS;
                end else if (i_sts.last_pass) begin
                    o_cmd.pass_next  = 1'b1;
                    o_cmd.drain_init = 1'b1;
                    n_state          = S_DRN_RD;
                end else begin
                    o_cmd.pass_next = 1'b1;
                    n_state         = S_PASS;
                end
            end
            S_DRN_RD: begin
                o_cmd.drain_rd = 1'b1;
                n_state        = S_DRN_OUT;
            end
            S_DRN_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.drain_out = 1'b1;
                    n_state         = i_sts.drain_last ? S_LOAD : S_DRN_RD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- hdl/masked_key_record_sorter_unit.sv -----
// Top level: stable batch sorter of 64-bit records on their low 40-bit key.
// Loading takes one record per cycle; a batch of n records then takes ceil(log2 n) merge
// passes, each merge step reading the heads of both runs and then writing the smaller,
// since it waits on the registered read of the record memory; draining reads one record
// at a time and hands it to the output register, waiting while that register is full.
// Reset (synchronous, active low) empties the batch and clears overflow; no clearing pass.
`timescale 1ns / 1ps

module masked_key_record_sorter_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    mkrs_rec_if.sink       i_rec,
    mkrs_res_if.source     o_res
);

    mkrs_pkg::t_cmd w_cmd;
    mkrs_pkg::t_sts w_sts;

    // Sequencer.
    mkrs_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_rec.valid),
        .i_in_batch_end (i_rec.batch_end),
        .i_sts          (w_sts),
        .o_in_ready     (i_rec.ready),
        .o_cmd          (w_cmd)
    );

    // Storage, merge logic and result register.
    mkrs_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_record        (i_rec.record),
        .o_out_valid     (o_res.valid),
        .i_out_ready     (o_res.ready),
        .o_sorted_record (o_res.sorted_record),
        .o_final_flag    (o_res.final_flag),
        .o_overflow      (o_res.overflow)
    );

endmodule
